// File: hw/rtl/ide_cartridge_bus_bridge_macros.svh
// Assertion macros used by the bridge top level.
`ifndef IDE_CARTRIDGE_BUS_BRIDGE_MACROS_SVH
`define IDE_CARTRIDGE_BUS_BRIDGE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BB_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define BB_ASSERT_NEXT(label, clk, rstn, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define BB_ASSERT_IMPL(label, clk, rstn, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (expr)) \
        else $error(msg);

`endif

// File: hw/rtl/ide_bb_pkg.sv
// Types and constants of the IDE cartridge bus bridge.
`timescale 1ns / 1ps

package ide_bb_pkg;

    // ROM banking: the bank number sits above the in-bank offset.
    localparam int BANK_BYTES = 16384;
    localparam int BANK_OFS_W = $clog2(BANK_BYTES);
    localparam int BANK_W     = 3;
    localparam int ROM_ADDR_W = BANK_W + BANK_OFS_W;

    // Address decode masks and matches.
    localparam logic [15:0] CTRL_MASK  = 16'hbf04;
    localparam logic [15:0] CTRL_MATCH = 16'h0104;
    localparam logic [15:0] DATA_MASK  = 16'h3e00;
    localparam logic [15:0] DATA_MATCH = 16'h3c00;
    localparam logic [15:0] TF_MASK    = 16'h3f00;
    localparam logic [15:0] TF_MATCH   = 16'h3e00;

    // Task-file register numbers with special handling.
    localparam logic [3:0] REG_DATA     = 4'd0;
    localparam logic [3:0] REG_DEVICE   = 4'd6;
    localparam logic [3:0] REG_STATUS   = 4'd7;
    localparam logic [3:0] REG_DEV_CTRL = 4'd14;

    // Fixed byte values returned when no drive answers.
    localparam logic [7:0]  BYTE_OPEN   = 8'hff;
    localparam logic [7:0]  BYTE_NODEV  = 8'h7f;
    localparam logic [15:0] WORD_NODEV  = 16'h7f7f;

    // Commands issued to the drive.
    typedef enum logic [2:0] {
        DOP_NONE    = 3'd0,
        DOP_DATA_RD = 3'd1,
        DOP_DATA_WR = 3'd2,
        DOP_REG_RD  = 3'd3,
        DOP_REG_WR  = 3'd4,
        DOP_RESET   = 3'd5
    } drive_op_t;

    // Bridge state carried from one access to the next.
    typedef struct packed {
        logic              regs_enabled;
        logic [BANK_W-1:0] rom_bank;
        logic [7:0]        read_high;
        logic [7:0]        write_low;
        logic              srst_active;
        logic              slave_sel;
    } bridge_state_t;

    // One result item.
    typedef struct packed {
        logic [15:0]           drive_write_data;
        logic [3:0]            drive_reg;
        drive_op_t             drive_op;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  read_from_rom;
        logic [7:0]            read_data;
    } bridge_result_t;

endpackage

// File: hw/rtl/ide_bb_decode.sv
// Address decode and access handling for one bus transfer.
`timescale 1ns / 1ps

module ide_bb_decode
    import ide_bb_pkg::*;
(
    input  bridge_state_t  st,
    input  logic           rom_present,
    input  logic           operation,
    input  logic [15:0]    address,
    input  logic [7:0]     write_value,
    input  logic [15:0]    drive_data,
    output bridge_result_t res,
    output bridge_state_t  st_next
);

    logic       ctrl_hit;
    logic       data_hit;
    logic       tf_hit;
    logic       rom_hit;
    logic [3:0] reg_num;
    logic [3:0] reg_rd;
    logic       sel_eff;
    logic [7:0] reg_val;

    // Region decode; the data window and task file need the register enable.
    assign ctrl_hit = (address & CTRL_MASK) == CTRL_MATCH;
    assign data_hit = st.regs_enabled && ((address & DATA_MASK) == DATA_MATCH);
    assign tf_hit   = st.regs_enabled && ((address & TF_MASK) == TF_MATCH);
    assign rom_hit  = address[15:14] == 2'b01;
    assign reg_num  = address[3:0];

    // Reads of the device control register alias to the status register.
    assign reg_rd   = (reg_num == REG_DEV_CTRL) ? REG_STATUS : reg_num;

    // A device register write updates the select before the write is judged.
    assign sel_eff  = (reg_num == REG_DEVICE) ? write_value[4] : st.slave_sel;

    // Register read value, with the device select shown in the device register.
    always_comb begin
        reg_val = st.slave_sel ? BYTE_NODEV : drive_data[7:0];
        if (reg_rd == REG_DEVICE) begin
            reg_val[4] = st.slave_sel;
        end
    end

    // Access handling.
    always_comb begin
        st_next = st;
        res     = '0;
        if (!rom_present) begin
            if (!operation) begin
                res.read_data = BYTE_OPEN;
            end
        end else if (!operation) begin
            if (data_hit) begin
                if (!address[0]) begin
                    if (st.slave_sel) begin
                        st_next.read_high = WORD_NODEV[15:8];
                        res.read_data     = WORD_NODEV[7:0];
                    end else begin
                        res.drive_op      = DOP_DATA_RD;
                        st_next.read_high = drive_data[15:8];
                        res.read_data     = drive_data[7:0];
                    end
                end else begin
                    res.read_data = st.read_high;
                end
            end else if (tf_hit) begin
                if (st.srst_active) begin
                    res.read_data = (reg_rd == REG_STATUS) ? BYTE_OPEN : BYTE_NODEV;
                end else if (reg_rd == REG_DATA) begin
                    if (st.slave_sel) begin
                        res.read_data = BYTE_NODEV;
                    end else begin
                        res.drive_op  = DOP_DATA_RD;
                        res.read_data = drive_data[7:0];
                    end
                end else begin
                    res.read_data = reg_val;
                    if (!st.slave_sel) begin
                        res.drive_op  = DOP_REG_RD;
                        res.drive_reg = reg_rd;
                    end
                end
            end else if (rom_hit) begin
                res.read_from_rom = 1'b1;
                res.rom_address   = {st.rom_bank, address[BANK_OFS_W-1:0]};
            end else begin
                res.read_data = BYTE_OPEN;
            end
        end else begin
            if (ctrl_hit) begin
                // Bank bits come from data bits 7..5 in reversed order.
                st_next.regs_enabled = write_value[0];
                st_next.rom_bank     = {write_value[5], write_value[6], write_value[7]};
            end else if (data_hit) begin
                if (!address[0]) begin
                    st_next.write_low = write_value;
                end else if (!st.slave_sel) begin
                    res.drive_op         = DOP_DATA_WR;
                    res.drive_write_data = {write_value, st.write_low};
                end
            end else if (tf_hit) begin
                if (st.srst_active) begin
                    if ((reg_num == REG_DEV_CTRL) && !write_value[2]) begin
                        st_next.srst_active = 1'b0;
                    end
                end else if (reg_num == REG_DATA) begin
                    if (!st.slave_sel) begin
                        res.drive_op         = DOP_DATA_WR;
                        res.drive_write_data = {write_value, write_value};
                    end
                end else if ((reg_num == REG_DEV_CTRL) && write_value[2]) begin
                    st_next.srst_active = 1'b1;
                    res.drive_op        = DOP_RESET;
                end else begin
                    st_next.slave_sel = sel_eff;
                    if (!sel_eff) begin
                        res.drive_op         = DOP_REG_WR;
                        res.drive_reg        = reg_num;
                        res.drive_write_data = {8'h00, write_value};
                    end
                end
            end
        end
    end

endmodule

// File: hw/rtl/ide_cartridge_bus_bridge.sv
// Top level of the IDE cartridge bus bridge: state, config and output skid stage.
`timescale 1ns / 1ps
//
// Channel   Direction  tdata (low bit first)                        tuser
// s_        in         address, write_value, drive_data             operation
// m_        out        read_data, rom_address, drive_op, drive_reg,  read_from_rom
//                      drive_write_data
// cfg_      in         rom_present                                  -
//
// Each transfer is decoded in the cycle it is accepted; its result is registered
// in the output or skid register. One transfer per cycle while s_tready is high.
// The output register plus a one-entry skid stage let a new transfer be taken
// while a result waits; s_tready drops only while the skid stage is full.
// Synchronous active-low reset loads STATE_RESET, clears config and both valid flags.

`include "ide_cartridge_bus_bridge_macros.svh"

module ide_cartridge_bus_bridge
    import ide_bb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[15:0], write_value[23:16], drive_data[39:24]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_data[7:0], rom_address[24:8], drive_op[27:25],
                                   // drive_reg[31:28], drive_write_data[47:32]
    output logic        m_tuser,   // read_from_rom
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam bridge_state_t STATE_RESET = '{
        regs_enabled: 1'b1,
        rom_bank:     '1,
        read_high:    8'h00,
        write_low:    8'h00,
        srst_active:  1'b0,
        slave_sel:    1'b0
    };

    bridge_state_t  state_reg;
    bridge_state_t  state_next;
    logic           rom_present_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    bridge_result_t out_res_reg;
    bridge_result_t out_res_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    bridge_result_t skid_res_reg;
    bridge_result_t skid_res_next;
    bridge_result_t dec_res;
    bridge_state_t  dec_state;
    logic           in_xfer;
    logic           out_free;

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Per-transfer decode.
    ide_bb_decode u_decode (
        .st          (state_reg),
        .rom_present (rom_present_reg),
        .operation   (s_tuser),
        .address     (s_tdata[15:0]),
        .write_value (s_tdata[23:16]),
        .drive_data  (s_tdata[39:24]),
        .res         (dec_res),
        .st_next     (dec_state)
    );

    // State advances on every accepted transfer.
    assign state_next = in_xfer ? dec_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_present_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            rom_present_reg <= cfg_data;
        end
    end

    // Output register and skid stage steering.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = in_xfer;
                out_res_next    = dec_res;
            end
        end else if (in_xfer) begin
            skid_valid_next = 1'b1;
            skid_res_next   = dec_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    // Result port packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.read_from_rom;
    assign m_tdata  = {out_res_reg.drive_write_data, out_res_reg.drive_reg,
                       out_res_reg.drive_op, out_res_reg.rom_address,
                       out_res_reg.read_data};

    // A full skid stage always sits behind a valid output register.
    `BB_ASSERT_ALWAYS(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || out_valid_reg, "skid full with empty output")

    // A ROM read never carries a drive command.
    `BB_ASSERT_IMPL(a_rom_no_cmd, aclk, aresetn, m_tvalid && m_tuser, out_res_reg.drive_op == DOP_NONE, "ROM read with drive command")

    // Soft reset only starts together with a drive reset command.
    `BB_ASSERT_IMPL(a_srst_cmd, aclk, aresetn, $rose(state_reg.srst_active), $past(in_xfer) && $past(dec_res.drive_op == DOP_RESET), "soft reset without drive reset")

    // A result that is stalled is still offered in the next cycle.
    `BB_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "stalled result dropped")

endmodule

// File: sim/ide_cartridge_bus_bridge_test.sv
// Self-checking testbench of the IDE cartridge bus bridge.
`timescale 1ns / 1ps

module ide_cartridge_bus_bridge_test
    import ide_bb_pkg::*;
;

    // Bit positions inside task-file register bytes.
    localparam int DEV_SEL_BIT = 4;
    localparam int SRST_BIT    = 2;

    // ROM window on the host bus.
    localparam logic [15:0] ROM_LO = 16'h4000;
    localparam logic [15:0] ROM_HI = 16'h7fff;

    // Bus access kinds.
    localparam bit BUS_RD = 1'b0;
    localparam bit BUS_WR = 1'b1;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 1500;
    // Cycles the receiver holds off once, so the bridge fills up.
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AT     = 500;

    // Tracks the bridge state and the results it should produce.
    class bridge_scoreboard;
        bit               rom_present;
        bit               regs_enabled;
        logic [BANK_W-1:0] rom_bank;
        logic [7:0]       read_high;
        logic [7:0]       write_low;
        bit               srst_active;
        bit               slave_sel;
        bridge_result_t   expected_q[$];
        int               mismatches;
        int               results_seen;

        function new();
            rom_present  = 1'b0;
            regs_enabled = 1'b1;
            rom_bank     = 3'd7;
            read_high    = 8'h00;
            write_low    = 8'h00;
            srst_active  = 1'b0;
            slave_sel    = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // The control byte holds the register enable in bit 0 and the bank bit-reversed in 7..5.
        function void load_control(logic [7:0] v);
            regs_enabled = v[0];
            rom_bank     = {v[5], v[6], v[7]};
        endfunction

        // Works out the result of one accepted bus access and updates the state.
        function void note_access(bit is_wr, logic [15:0] addr, logic [7:0] wv,
                                  logic [15:0] dd);
            bridge_result_t r;
            logic [3:0]     rn;
            logic [7:0]     v;
            logic [15:0]    word;
            bit             in_data;
            bit             in_tf;

            r          = '0;
            r.drive_op = DOP_NONE;
            rn         = addr[3:0];
            in_data    = regs_enabled && ((addr & DATA_MASK) == DATA_MATCH);
            in_tf      = regs_enabled && ((addr & TF_MASK) == TF_MATCH);

            if (!rom_present) begin
                if (!is_wr) r.read_data = BYTE_OPEN;
            end else if (!is_wr) begin
                if (in_data) begin
                    // Even address fetches a word; odd address returns the latched high byte.
                    if (!addr[0]) begin
                        word = WORD_NODEV;
                        if (!slave_sel) begin
                            r.drive_op = DOP_DATA_RD;
                            word       = dd;
                        end
                        read_high   = word[15:8];
                        r.read_data = word[7:0];
                    end else begin
                        r.read_data = read_high;
                    end
                end else if (in_tf) begin
                    if (rn == REG_DEV_CTRL) rn = REG_STATUS;
                    if (srst_active) begin
                        r.read_data = (rn == REG_STATUS) ? BYTE_OPEN : BYTE_NODEV;
                    end else if (rn == REG_DATA) begin
                        if (slave_sel) begin
                            r.read_data = BYTE_NODEV;
                        end else begin
                            r.drive_op  = DOP_DATA_RD;
                            r.read_data = dd[7:0];
                        end
                    end else begin
                        v = BYTE_NODEV;
                        if (!slave_sel) begin
                            r.drive_op  = DOP_REG_RD;
                            r.drive_reg = rn;
                            v           = dd[7:0];
                        end
                        if (rn == REG_DEVICE) v[DEV_SEL_BIT] = slave_sel;
                        r.read_data = v;
                    end
                end else if (addr >= ROM_LO && addr <= ROM_HI) begin
                    r.read_from_rom = 1'b1;
                    r.rom_address   = {rom_bank, addr[BANK_OFS_W-1:0]};
                end else begin
                    r.read_data = BYTE_OPEN;
                end
            end else begin
                if ((addr & CTRL_MASK) == CTRL_MATCH) begin
                    load_control(wv);
                end else if (in_data) begin
                    if (!addr[0]) begin
                        write_low = wv;
                    end else if (!slave_sel) begin
                        r.drive_op         = DOP_DATA_WR;
                        r.drive_write_data = {wv, write_low};
                    end
                end else if (in_tf) begin
                    if (srst_active) begin
                        // Only a device-control write with the reset bit clear ends it.
                        if (rn == REG_DEV_CTRL && !wv[SRST_BIT]) srst_active = 1'b0;
                    end else if (rn == REG_DATA) begin
                        if (!slave_sel) begin
                            r.drive_op         = DOP_DATA_WR;
                            r.drive_write_data = {wv, wv};
                        end
                    end else if (rn == REG_DEV_CTRL && wv[SRST_BIT]) begin
                        srst_active = 1'b1;
                        r.drive_op  = DOP_RESET;
                    end else begin
                        if (rn == REG_DEVICE) slave_sel = wv[DEV_SEL_BIT];
                        if (!slave_sel) begin
                            r.drive_op         = DOP_REG_WR;
                            r.drive_reg        = rn;
                            r.drive_write_data = {8'h00, wv};
                        end
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void report_field(string name, logic [16:0] want, logic [16:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h",
                             $time, name, want, got);
            end
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_result(logic [47:0] data, logic user);
            bridge_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result 0x%0h arrived with nothing expected", $time, data);
                return;
            end
            want = expected_q.pop_front();
            report_field("read_data",        17'(want.read_data),        17'(data[7:0]));
            report_field("read_from_rom",    17'(want.read_from_rom),    17'(user));
            report_field("rom_address",      17'(want.rom_address),      17'(data[24:8]));
            report_field("drive_op",         17'(want.drive_op),         17'(data[27:25]));
            report_field("drive_reg",        17'(want.drive_reg),        17'(data[31:28]));
            report_field("drive_write_data", 17'(want.drive_write_data), 17'(data[47:32]));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // address[15:0], write_value[23:16], drive_data[39:24]
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // read_data[7:0], rom_address[24:8], drive_op[27:25],
                            // drive_reg[31:28], drive_write_data[47:32]
    logic        m_tuser;   // read_from_rom
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    bridge_scoreboard sb = new();
    int               idle_pct;

    ide_cartridge_bus_bridge u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 15);
        return $urandom_range(3, 1);
    endfunction

    // Offers one bus access and waits for its transfer.
    task automatic send_access(bit is_wr, logic [15:0] addr, logic [7:0] wv,
                               logic [15:0] dd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dd, wv, addr};
        s_tuser  <= is_wr;
        do @(posedge aclk); while (!s_tready);
        sb.note_access(is_wr, addr, wv, dd);
    endtask

    // Writes rom_present once every expected result is back and the bridge is idle.
    task automatic write_rom_present(bit v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.rom_present = v;
        cfg_valid <= 1'b0;
    endtask

    // Random accesses, weighted toward the decoded regions.
    task automatic run_random_accesses(int count);
        logic [15:0] addr;
        logic [15:0] rnd;
        int          pick;
        for (int i = 0; i < count; i++) begin
            rnd  = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 8) begin
                addr = (rnd & ~CTRL_MASK) | CTRL_MATCH;
            end else if (pick < 38) begin
                addr = (rnd & ~DATA_MASK) | DATA_MATCH;
            end else if (pick < 73) begin
                addr = (rnd & ~TF_MASK) | TF_MATCH;
                // Favor the registers with special handling.
                if ($urandom_range(1) == 0) begin
                    case ($urandom_range(3))
                        0: addr[3:0] = REG_DATA;
                        1: addr[3:0] = REG_DEVICE;
                        2: addr[3:0] = REG_STATUS;
                        default: addr[3:0] = REG_DEV_CTRL;
                    endcase
                end
            end else if (pick < 88) begin
                addr = ROM_LO | (rnd & 16'h3fff);
            end else begin
                addr = rnd;
            end
            send_access(bit'($urandom_range(1)), addr, 8'($urandom), 16'($urandom));
        end
    endtask

    // Result side: checks transfers and stalls at random, with one long hold-off.
    initial begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (!held && sb.results_seen >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("ide_cartridge_bus_bridge regression: fail");
        $finish;
    end

    // Reset, directed accesses, random phases and the final verdict.
    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        aresetn   <= 1'b0;
        idle_pct   = 20;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Cartridge absent: reads float high, writes vanish.
        send_access(BUS_RD, DATA_MATCH, 8'h00, 16'hffff);
        send_access(BUS_WR, CTRL_MATCH, 8'h00, 16'h0000);
        write_rom_present(1'b1);

        // ROM window edges with the reset bank, and open addresses.
        send_access(BUS_RD, ROM_LO, 8'hff, 16'h0000);
        send_access(BUS_RD, ROM_HI, 8'h00, 16'hffff);
        send_access(BUS_RD, 16'h0000, 8'h00, 16'h0000);
        send_access(BUS_RD, 16'hffff, 8'hff, 16'hffff);

        // Control writes: bank bits reversed, register enable off and on again.
        send_access(BUS_WR, CTRL_MATCH, 8'h81, 16'h0000);
        send_access(BUS_RD, 16'h4abc, 8'h00, 16'h0000);
        send_access(BUS_WR, CTRL_MATCH, 8'h20, 16'h0000);
        send_access(BUS_RD, DATA_MATCH, 8'h00, 16'h1234);
        send_access(BUS_RD, 16'h5000, 8'h00, 16'h0000);
        send_access(BUS_WR, 16'h41fd, 8'hff, 16'h0000);

        // Data window in both directions through the byte latches.
        send_access(BUS_WR, DATA_MATCH, 8'h34, 16'h0000);
        send_access(BUS_WR, DATA_MATCH | 16'h0001, 8'h12, 16'h0000);
        send_access(BUS_RD, DATA_MATCH, 8'h00, 16'hbeef);
        send_access(BUS_RD, DATA_MATCH | 16'h0001, 8'h00, 16'h0000);

        // Task file: byte data path, status and its alias, device select.
        send_access(BUS_RD, TF_MATCH | REG_DATA, 8'h00, 16'h5aa5);
        send_access(BUS_WR, TF_MATCH | REG_DATA, 8'h3c, 16'h0000);
        send_access(BUS_RD, TF_MATCH | REG_STATUS, 8'h00, 16'h0050);
        send_access(BUS_RD, TF_MATCH | REG_DEV_CTRL, 8'h00, 16'h0041);
        send_access(BUS_WR, TF_MATCH | REG_DEVICE, 8'h10, 16'h0000);
        send_access(BUS_RD, TF_MATCH | REG_DEVICE, 8'h00, 16'h00ff);
        send_access(BUS_RD, DATA_MATCH, 8'h00, 16'h0000);
        send_access(BUS_WR, TF_MATCH | REG_DEVICE, 8'h00, 16'h0000);

        // Soft reset: start, reads while active, then release.
        send_access(BUS_WR, TF_MATCH | REG_DEV_CTRL, 8'h04, 16'h0000);
        send_access(BUS_RD, TF_MATCH | REG_STATUS, 8'h00, 16'h0000);
        send_access(BUS_RD, TF_MATCH | 16'h0003, 8'h00, 16'h0000);
        send_access(BUS_WR, TF_MATCH | REG_DEV_CTRL, 8'h00, 16'h0000);

        // Random phases with different idling and cartridge settings.
        idle_pct = 0;
        run_random_accesses(300);
        idle_pct = 30;
        write_rom_present(1'b1);
        run_random_accesses(300);
        idle_pct = 25;
        write_rom_present(1'b0);
        run_random_accesses(150);
        idle_pct = 50;
        write_rom_present(1'b1);
        run_random_accesses(350);
        idle_pct = 10;
        run_random_accesses(350);
        idle_pct = 35;
        write_rom_present(1'b0);
        write_rom_present(1'b1);
        run_random_accesses(275);

        // Drain and let any stray result show up.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ide_cartridge_bus_bridge regression: pass");
        else
            $display("ide_cartridge_bus_bridge regression: fail");
        $finish;
    end

endmodule
